/* hdl/assert_macros.svh */
// shared concurrent assertion macros, clocked on clk_i and disabled in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PWFT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define PWFT_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define PWFT_ASSERT(label, prop, msg)

`define PWFT_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* hdl/pwft_pkg.sv */
package pwft_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned PulseW    = 6;
  localparam int unsigned TickW     = 8;
  localparam int unsigned BitCntW   = 5;
  localparam int unsigned ShiftW    = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned OutDataW  = 8;

  localparam logic [BitCntW-1:0] FrameBits = BitCntW'(16);

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegPreamblePulses = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHalfPulseTicks = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGapTicks       = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShortHighTicks = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLongHighTicks  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBitLowTicks    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCheckMask      = 3'd6;

  // reset values
  localparam logic [PulseW-1:0] RstPreamblePulses = 6'd20;
  localparam logic [TickW-1:0]  RstHalfPulseTicks = 8'd5;
  localparam logic [TickW-1:0]  RstGapTicks       = 8'd1;
  localparam logic [TickW-1:0]  RstShortHighTicks = 8'd10;
  localparam logic [TickW-1:0]  RstLongHighTicks  = 8'd20;
  localparam logic [TickW-1:0]  RstBitLowTicks    = 8'd10;
  localparam logic [ByteW-1:0]  RstCheckMask      = 8'hAA;

  // input command codes
  localparam logic CmdTick = 1'b0;
  localparam logic CmdSend = 1'b1;

  typedef struct packed {
    logic [PulseW-1:0] preamble_pulses;
    logic [TickW-1:0]  half_pulse_ticks;
    logic [TickW-1:0]  gap_ticks;
    logic [TickW-1:0]  short_high_ticks;
    logic [TickW-1:0]  long_high_ticks;
    logic [TickW-1:0]  bit_low_ticks;
    logic [ByteW-1:0]  check_mask;
  } cfg_t;

  typedef struct packed {
    logic frame_done;
    logic busy_res;
    logic line_level;
  } result_t;

  // zero lengths count as one
  function automatic logic [TickW-1:0] span_len(input logic [TickW-1:0] len);
    span_len = (len == '0) ? TickW'(1) : len;
  endfunction

endpackage

/* hdl/pulse_width_frame_transmitter.sv */
// Pulse-width frame transmitter. Each input transaction is either a 100 us tick
// (tuser = 0) or a send request (tuser = 1, data byte in tdata); a send while a
// frame is running is ignored. Every input transaction yields exactly one result
// transaction carrying the transmit line level, a busy flag and a frame-done
// pulse. A frame is a preamble of square pulses, an optional low gap, then the
// data byte and the check byte (data AND check_mask), most significant bit
// first, each bit high for a short (0) or long (1) time then low. One item is
// taken every clock cycle while the output buffer has room: the frame state is
// registered from the accepted item, and a two-entry output buffer keeps input
// flowing while the result side stalls, until its second entry fills. Configuration
// writes are always accepted; unknown indexes are dropped.
module pulse_width_frame_transmitter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwft_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pwft_pkg::CfgDataW-1:0]   cfg_data_i,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [pwft_pkg::ByteW-1:0]      s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tuser,  // [0] command
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pwft_pkg::OutDataW-1:0]   m_axis_tdata   // [0] line_level, [1] busy_res,
                                                         // [2] frame_done, [7:3] zero
);

  pwft_pkg::cfg_t    cfg;
  pwft_pkg::result_t seq_res, buf_res;
  logic              in_fire, buf_ready;

  assign s_axis_tready = buf_ready;
  assign in_fire       = s_axis_tvalid && buf_ready;

  pwft_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pwft_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_fire_i   (in_fire),
    .command_i   (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .result_o    (seq_res)
  );

  pwft_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_fire),
    .ready_o     (buf_ready),
    .data_i      (seq_res),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .data_o      (buf_res)
  );

  assign m_axis_tdata = {5'b0, buf_res.frame_done, buf_res.busy_res, buf_res.line_level};

endmodule

/* hdl/pwft_cfg.sv */
module pwft_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwft_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwft_pkg::CfgDataW-1:0] cfg_data_i,
  output pwft_pkg::cfg_t                cfg_o
);

  pwft_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_index_i)
        pwft_pkg::RegPreamblePulses:
          cfg_d.preamble_pulses = cfg_data_i[pwft_pkg::PulseW-1:0];
        pwft_pkg::RegHalfPulseTicks: cfg_d.half_pulse_ticks = cfg_data_i;
        pwft_pkg::RegGapTicks:       cfg_d.gap_ticks        = cfg_data_i;
        pwft_pkg::RegShortHighTicks: cfg_d.short_high_ticks = cfg_data_i;
        pwft_pkg::RegLongHighTicks:  cfg_d.long_high_ticks  = cfg_data_i;
        pwft_pkg::RegBitLowTicks:    cfg_d.bit_low_ticks    = cfg_data_i;
        pwft_pkg::RegCheckMask:      cfg_d.check_mask       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_pulses  <= pwft_pkg::RstPreamblePulses;
      cfg_q.half_pulse_ticks <= pwft_pkg::RstHalfPulseTicks;
      cfg_q.gap_ticks        <= pwft_pkg::RstGapTicks;
      cfg_q.short_high_ticks <= pwft_pkg::RstShortHighTicks;
      cfg_q.long_high_ticks  <= pwft_pkg::RstLongHighTicks;
      cfg_q.bit_low_ticks    <= pwft_pkg::RstBitLowTicks;
      cfg_q.check_mask       <= pwft_pkg::RstCheckMask;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/pwft_seq.sv */
`include "assert_macros.svh"

module pwft_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pwft_pkg::cfg_t             cfg_i,
  input  logic                       in_fire_i,
  input  logic                       command_i,
  input  logic [pwft_pkg::ByteW-1:0] data_byte_i,
  output pwft_pkg::result_t          result_o
);

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhPreHi = 3'd1,
    PhPreLo = 3'd2,
    PhGap   = 3'd3,
    PhBitHi = 3'd4,
    PhBitLo = 3'd5
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [pwft_pkg::PulseW-1:0]   pulse_q, pulse_d, pulse_inc, pulse_n;
  logic [pwft_pkg::BitCntW-1:0]  bit_q, bit_d, bit_inc;
  logic [pwft_pkg::TickW-1:0]    tick_q, tick_d, tick_inc, cur_len;
  logic [pwft_pkg::ShiftW-1:0]   shift_q, shift_d;
  logic                          line_q, line_d;
  logic                          span_end, done;

  assign tick_inc  = tick_q + pwft_pkg::TickW'(1);
  assign pulse_inc = pulse_q + pwft_pkg::PulseW'(1);
  assign bit_inc   = bit_q + pwft_pkg::BitCntW'(1);
  assign pulse_n   = (cfg_i.preamble_pulses == '0) ? pwft_pkg::PulseW'(1)
                                                    : cfg_i.preamble_pulses;

  // length of the span counted in the current phase
  always_comb begin
    case (phase_q)
      PhPreHi, PhPreLo: cur_len = cfg_i.half_pulse_ticks;
      PhGap:            cur_len = cfg_i.gap_ticks;
      PhBitHi:          cur_len = shift_q[pwft_pkg::ShiftW-1] ? cfg_i.long_high_ticks
                                                              : cfg_i.short_high_ticks;
      PhBitLo:          cur_len = cfg_i.bit_low_ticks;
      default:          cur_len = pwft_pkg::TickW'(1);
    endcase
  end

  assign span_end = tick_inc >= pwft_pkg::span_len(cur_len);

  always_comb begin
    phase_d = phase_q;
    pulse_d = pulse_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    line_d  = line_q;
    done    = 1'b0;
    if (command_i == pwft_pkg::CmdSend) begin
      if (phase_q == PhIdle) begin
        shift_d = {data_byte_i, data_byte_i & cfg_i.check_mask};
        phase_d = PhPreHi;
        pulse_d = '0;
        bit_d   = '0;
        tick_d  = '0;
        line_d  = 1'b1;
      end
    end else begin
      case (phase_q)
        PhIdle: ;
        PhPreHi, PhPreLo, PhGap, PhBitHi, PhBitLo: begin
          tick_d = span_end ? '0 : tick_inc;
          if (span_end) begin
            case (phase_q)
              PhPreHi: begin
                phase_d = PhPreLo;
                line_d  = 1'b0;
              end
              PhPreLo: begin
                if (pulse_inc >= pulse_n) begin
                  pulse_d = '0;
                  // zero gap goes straight to the first bit
                  if (cfg_i.gap_ticks == '0) begin
                    phase_d = PhBitHi;
                    line_d  = 1'b1;
                  end else begin
                    phase_d = PhGap;
                    line_d  = 1'b0;
                  end
                end else begin
                  pulse_d = pulse_inc;
                  phase_d = PhPreHi;
                  line_d  = 1'b1;
                end
              end
              PhGap: begin
                phase_d = PhBitHi;
                line_d  = 1'b1;
              end
              PhBitHi: begin
                phase_d = PhBitLo;
                line_d  = 1'b0;
              end
              default: begin
                shift_d = {shift_q[pwft_pkg::ShiftW-2:0], 1'b0};
                if (bit_inc >= pwft_pkg::FrameBits) begin
                  bit_d   = '0;
                  phase_d = PhIdle;
                  line_d  = 1'b0;
                  done    = 1'b1;
                end else begin
                  bit_d   = bit_inc;
                  phase_d = PhBitHi;
                  line_d  = 1'b1;
                end
              end
            endcase
          end
        end
        default: begin
          phase_d = PhIdle;
          line_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pulse_q <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      line_q  <= 1'b0;
    end else if (in_fire_i) begin
      phase_q <= phase_d;
      pulse_q <= pulse_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      line_q  <= line_d;
    end
  end

  assign result_o.line_level = line_d;
  assign result_o.busy_res   = phase_d != PhIdle;
  assign result_o.frame_done = done;

  `PWFT_ASSERT(a_idle_line_low, (phase_q == PhIdle) |-> !line_q, "line high while idle")
  `PWFT_ASSERT(a_line_high_phase, line_q |-> (phase_q == PhPreHi || phase_q == PhBitHi), "line high outside a high span")
  `PWFT_ASSERT_NEVER(a_done_busy, in_fire_i && result_o.frame_done && result_o.busy_res, "frame done while still busy")

endmodule

/* hdl/pwft_obuf.sv */
`include "assert_macros.svh"

module pwft_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  pwft_pkg::result_t data_i,
  output logic              valid_o,
  input  logic              pop_ready_i,
  output pwft_pkg::result_t data_o
);

  pwft_pkg::result_t out_q, skid_q;
  logic              out_valid_q, skid_valid_q, pop;

  assign ready_o = !skid_valid_q;
  assign pop     = out_valid_q && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else if (!push_i) begin
          out_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  // payload path, no reset
  always_ff @(posedge clk_i) begin
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (push_i && (pop || !out_valid_q)) begin
      out_q <= data_i;
    end
    if (push_i && out_valid_q && !pop) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  `PWFT_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `PWFT_ASSERT(a_stall_fills_skid, (push_i && out_valid_q && !pop_ready_i) |=> skid_valid_q, "stalled transaction lost")

endmodule
